@@ rtl/utf8_to_utf16_decoder_core_assert.svh @@
// Assertion macros used by the transcoder core.
`ifndef UTF8_TO_UTF16_DECODER_CORE_ASSERT_SVH
`define UTF8_TO_UTF16_DECODER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("transcoder assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("transcoder assertion failed");

`else

`define ASSERT_SAME(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

@@ rtl/u8u16_pkg.sv @@
// Types and constants of the UTF-8 to UTF-16 transcoder.
`timescale 1ns / 1ps

package u8u16_pkg;

   localparam int BYTE_W = 8;
   localparam int UNIT_W = 16;

   localparam logic [UNIT_W-1:0] REPLACEMENT_CHAR = 16'hFFFD;
   localparam logic [UNIT_W-1:0] HI_SURR_BASE     = 16'hD800;
   localparam logic [UNIT_W-1:0] LO_SURR_BASE     = 16'hDC00;
   localparam logic [10:0]       HI_SURR_OFFSET   = 11'h040;
   localparam logic [15:0]       MAX_UNITS_RESET  = 16'd36;

   // Register index on the configuration port (paddr bit 2).
   localparam logic CSR_MAX_UNITS = 1'b0;

   typedef struct packed {
      logic [UNIT_W-1:0] code_unit;
      logic              last;
      logic              truncated;
   } unit_type;

endpackage

@@ rtl/u8u16_req_if.sv @@
// Input channel: one UTF-8 byte per word.
`timescale 1ns / 1ps

interface u8u16_req_if;
   import u8u16_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

@@ rtl/u8u16_rsp_if.sv @@
// Result channel: one UTF-16 code unit per word.
`timescale 1ns / 1ps

interface u8u16_rsp_if;
   import u8u16_pkg::*;

   logic              valid;
   logic              ready;
   logic [UNIT_W-1:0] code_unit;
   logic              last;
   logic              truncated;

   modport source (output valid, output code_unit, output last, output truncated,
                   input ready);
   modport sink   (input valid, input code_unit, input last, input truncated,
                   output ready);
endinterface

@@ rtl/utf8_to_utf16_decoder_core.sv @@
// Top level of the UTF-8 to UTF-16 stream transcoder.
`timescale 1ns / 1ps
`include "utf8_to_utf16_decoder_core_assert.svh"

// The block takes a NUL-terminated UTF-8 string on req_ch, one byte per word, and
// gives UTF-16 code units on rsp_ch, one unit per word, ending each string with a
// zero terminator word flagged by last. Unfinished sequences and stray continuation
// bytes become U+FFFD, and a string that would overrun max_units is cut with a
// terminator flagged truncated. Each accepted byte is decoded in the cycle it is
// accepted and its zero to two words are written into a three-entry result queue;
// the first word is on rsp_ch in the next cycle. A byte is accepted when the queue
// is empty, or holds one word that is taken in that same cycle, so while the
// receiver takes every word a byte giving at most one word streams at one byte per
// cycle. After a byte giving more than one word, the next byte waits until the last
// of them is being taken. When the receiver stalls, the queue holds its words and
// req_ch ready drops. Synchronous reset empties the queue, clears the decoder state
// and sets max_units to 36. max_units is written over the APB-style port at byte
// address 0 and should only change while the block is idle; zero acts as one.
module utf8_to_utf16_decoder_core (
   input  logic                clock,
   input  logic                reset,
   u8u16_req_if.sink           req_ch,
   u8u16_rsp_if.source         rsp_ch,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [2:0]          paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready
);
   import u8u16_pkg::*;

   typedef struct packed {
      unit_type    ent;
      logic        ended;
      logic [16:0] uw;
   } put_type;

   // One unit slot is used: bump the count and replace the unit by a terminator
   // if it is the terminator itself or the buffer is full.
   function automatic put_type put_unit(input logic [16:0] uw_i, input logic [16:0] cap_i,
                                        input logic [UNIT_W-1:0] unit_i, input logic term_i);
      put_type r;
      r.uw = uw_i + 17'd1;
      if (term_i) begin
         r.ent   = '{code_unit: '0, last: 1'b1, truncated: 1'b0};
         r.ended = 1'b1;
      end else if (r.uw >= cap_i) begin
         r.ent   = '{code_unit: '0, last: 1'b1, truncated: 1'b1};
         r.ended = 1'b1;
      end else begin
         r.ent   = '{code_unit: unit_i, last: 1'b0, truncated: 1'b0};
         r.ended = 1'b0;
      end
      return r;
   endfunction

   logic [15:0]       max_units_ff;
   logic [20:0]       accum_ff, accum_in;
   logic [1:0]        pend_ff, pend_in;
   logic              stray_ff, stray_in;
   logic [15:0]       uw_ff, uw_in;
   logic              drain_ff, drain_in;
   unit_type          q_ff [3];
   unit_type          q_in [3];
   logic [1:0]        cnt_ff, cnt_in;
   unit_type          new_q [3];
   logic [1:0]        n_new;

   logic              accept, pop, csr_write;
   logic [16:0]       cap;
   logic [BYTE_W-1:0] c;

   assign c      = req_ch.in_byte;
   assign cap    = (max_units_ff == 16'd0) ? 17'd1 : {1'b0, max_units_ff};
   assign pop    = rsp_ch.valid && rsp_ch.ready;
   assign accept = req_ch.valid && req_ch.ready;

   // Room for a whole byte's words once the current front word leaves.
   assign req_ch.ready = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && rsp_ch.ready);

   assign rsp_ch.valid     = (cnt_ff != 2'd0);
   assign rsp_ch.code_unit = q_ff[0].code_unit;
   assign rsp_ch.last      = q_ff[0].last;
   assign rsp_ch.truncated = q_ff[0].truncated;

   // Configuration port: writes complete in the access phase, reads return data.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign prdata    = (paddr[2] == CSR_MAX_UNITS) ? {16'd0, max_units_ff} : 32'd0;

   // Decode of one byte against the current string state.
   always_comb begin
      put_type     p;
      logic [20:0] cp;
      logic        big;
      logic        ended;
      logic        rdy;
      logic [16:0] uw;
      logic [10:0] hi_off;

      accum_in = accum_ff;
      pend_in  = pend_ff;
      stray_in = stray_ff;
      drain_in = drain_ff;
      uw_in    = uw_ff;
      n_new    = 2'd0;
      for (int i = 0; i < 3; i++) begin
         new_q[i] = '0;
      end
      ended  = 1'b0;
      rdy    = 1'b0;
      uw     = {1'b0, uw_ff};
      cp     = '0;
      big    = 1'b0;
      hi_off = '0;
      p      = '0;

      if (drain_ff) begin
         // Bytes of a cut string are dropped until its NUL.
         if (c == 8'd0) begin
            accum_in = '0;
            pend_in  = '0;
            stray_in = 1'b0;
            uw_in    = '0;
            drain_in = 1'b0;
         end
      end else begin
         if (c[7:6] != 2'b10) begin
            // Lead byte: flush an unfinished sequence or stray continuations first.
            if ((pend_ff != 2'd0) || stray_ff) begin
               p            = put_unit(uw, cap, REPLACEMENT_CHAR, 1'b0);
               uw           = p.uw;
               ended        = p.ended;
               new_q[n_new] = p.ent;
               n_new        = n_new + 2'd1;
            end
            if (!ended) begin
               stray_in = 1'b0;
               if (c[7:3] == 5'b11110) begin
                  accum_in = {18'd0, c[2:0]};
                  pend_in  = 2'd3;
               end else if (c[7:4] == 4'b1110) begin
                  accum_in = {17'd0, c[3:0]};
                  pend_in  = 2'd2;
               end else if (c[7:5] == 3'b110) begin
                  accum_in = {16'd0, c[4:0]};
                  pend_in  = 2'd1;
               end else begin
                  accum_in = {14'd0, c[6:0]};
                  pend_in  = 2'd0;
                  rdy      = 1'b1;
               end
            end
         end else if (pend_ff != 2'd0) begin
            accum_in = {accum_ff[14:0], c[5:0]};
            pend_in  = pend_ff - 2'd1;
            rdy      = (pend_ff == 2'd1);
         end else begin
            stray_in = 1'b1;
         end

         if (!ended && rdy) begin
            cp  = accum_in;
            big = (cp[20:16] != 5'd0);
            // A pair needs two unit slots and the terminator's.
            if (big && ((uw + 17'd2) >= cap)) begin
               cp  = {5'd0, REPLACEMENT_CHAR};
               big = 1'b0;
            end
            if (big) begin
               hi_off       = cp[20:10] - HI_SURR_OFFSET;
               p            = put_unit(uw, cap, HI_SURR_BASE | {5'd0, hi_off}, 1'b0);
               uw           = p.uw;
               ended        = p.ended;
               new_q[n_new] = p.ent;
               n_new        = n_new + 2'd1;
               if (!ended) begin
                  p            = put_unit(uw, cap, LO_SURR_BASE | {6'd0, cp[9:0]}, 1'b0);
                  uw           = p.uw;
                  ended        = p.ended;
                  new_q[n_new] = p.ent;
                  n_new        = n_new + 2'd1;
               end
            end else begin
               p            = put_unit(uw, cap, cp[15:0], (c == 8'd0));
               uw           = p.uw;
               ended        = p.ended;
               new_q[n_new] = p.ent;
               n_new        = n_new + 2'd1;
            end
         end

         uw_in = uw[15:0];
         if (ended) begin
            accum_in = '0;
            pend_in  = '0;
            stray_in = 1'b0;
            uw_in    = '0;
            drain_in = (c != 8'd0);
         end
      end
   end

   // Result queue: refilled on accept, shifted towards the front on a take.
   always_comb begin
      q_in   = q_ff;
      cnt_in = cnt_ff;
      if (accept) begin
         q_in   = new_q;
         cnt_in = n_new;
      end else if (pop) begin
         q_in[0] = q_ff[1];
         q_in[1] = q_ff[2];
         cnt_in  = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_units_ff <= MAX_UNITS_RESET;
         accum_ff     <= '0;
         pend_ff      <= '0;
         stray_ff     <= 1'b0;
         uw_ff        <= '0;
         drain_ff     <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         if (csr_write && (paddr[2] == CSR_MAX_UNITS)) begin
            max_units_ff <= pwdata[15:0];
         end
         if (accept) begin
            accum_ff <= accum_in;
            pend_ff  <= pend_in;
            stray_ff <= stray_in;
            uw_ff    <= uw_in;
            drain_ff <= drain_in;
         end
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
   end

   // A byte of a cut string never produces a word.
   `ASSERT_NEXT(a_drain_silent, clock, reset, accept && drain_ff, cnt_ff == 2'd0)
   // A terminator word is always the final word of its byte.
   `ASSERT_SAME(a_last_at_end, clock, reset, rsp_ch.valid && q_ff[0].last, cnt_ff == 2'd1)
   // After a terminator has been produced the unit count, pending sequence and stray flag are cleared.
   `ASSERT_NEXT(a_term_clears, clock, reset,
      accept && (n_new != 2'd0) && new_q[n_new - 2'd1].last,
      (uw_ff == 16'd0) && (pend_ff == 2'd0) && !stray_ff)

endmodule
